>>> design/rtkd_pkg.sv
// rtkd_pkg: types, fixed tables and byte helpers for the key derivation core
// depends on nothing; used by every design file
`default_nettype none
package rtkd_pkg;

  localparam int NBYTES  = 16;
  localparam int NROUNDS = 5;
  localparam int AES_NR  = 10;

  typedef logic [7:0] byte_t;
  typedef logic [0:NBYTES-1][7:0] blk_t;
  typedef logic [0:AES_NR][0:NBYTES-1][7:0] rkeys_t;
  typedef logic [0:255][7:0] sbox_t;

  typedef struct packed {
    logic [63:0] key_in_high;
    logic [63:0] key_in_low;
  } key_in_t;

  typedef struct packed {
    logic [63:0] derived_high;
    logic [63:0] derived_low;
  } derived_t;

  localparam sbox_t FWD_SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam blk_t AES_KEY = {
    8'h86,8'h9F,8'h77,8'h45,8'hC1,8'h3F,8'hD8,8'h90,
    8'hCC,8'hF2,8'h91,8'h88,8'hE3,8'hCC,8'h3E,8'hDF };
  localparam logic [0:NBYTES-1][3:0] PERM = {
    4'hC,4'h3,4'h6,4'h4,4'h1,4'hB,4'hF,4'h8,4'h2,4'h7,4'h0,4'h5,4'hA,4'hE,4'hD,4'h9 };
  localparam blk_t MASK_TAB = {
    8'hA9,8'h3E,8'h1F,8'hD6,8'h7C,8'h55,8'hA3,8'h29,
    8'hB7,8'h5F,8'hDD,8'hA6,8'h2A,8'h95,8'hC7,8'hA5 };
  localparam blk_t SUB_TAB = {
    8'h67,8'hD4,8'h5D,8'hA3,8'h29,8'h6D,8'h00,8'h6A,
    8'h4E,8'h7C,8'h53,8'h7B,8'hF5,8'h53,8'h8C,8'h74 };

  function automatic byte_t xt(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic sbox_t make_inv_sbox();
    sbox_t t;
    t = '0;
    for (int i = 0; i < 256; i++) t[FWD_SBOX[i]] = i[7:0];
    return t;
  endfunction

  function automatic rkeys_t make_rkeys();
    byte_t  w [176];
    byte_t  tmp [4];
    byte_t  rc;
    byte_t  x;
    rkeys_t rk;
    rc = 8'h01;
    for (int i = 0; i < NBYTES; i++) w[i] = AES_KEY[i];
    for (int i = NBYTES; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tmp[j] = w[i-4+j];
      if ((i % 16) == 0) begin
        x      = tmp[0];
        tmp[0] = FWD_SBOX[tmp[1]] ^ rc;
        tmp[1] = FWD_SBOX[tmp[2]];
        tmp[2] = FWD_SBOX[tmp[3]];
        tmp[3] = FWD_SBOX[x];
        rc     = xt(rc);
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ tmp[j];
    end
    for (int r = 0; r <= AES_NR; r++)
      for (int i = 0; i < NBYTES; i++) rk[r][i] = w[r*16+i];
    return rk;
  endfunction

  // subtrahend laid out with the first permuted byte least significant
  function automatic logic [127:0] make_sub_word();
    logic [127:0] v;
    for (int i = 0; i < NBYTES; i++) v[8*i +: 8] = SUB_TAB[PERM[i]];
    return v;
  endfunction

  localparam sbox_t        INV_SBOX = make_inv_sbox();
  localparam rkeys_t       RKEYS    = make_rkeys();
  localparam logic [127:0] SUB_WORD = make_sub_word();

endpackage
`default_nettype wire

>>> design/rtkd_aes_stage.sv
// rtkd_aes_stage: one registered aes-128 inverse round with a fixed round key
// depends on rtkd_pkg
`default_nettype none
module rtkd_aes_stage #(
  parameter int ROUND = 9
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_vld,
  input  wire rtkd_pkg::blk_t in_blk,
  output logic              out_vld,
  output rtkd_pkg::blk_t    out_blk
);
  import rtkd_pkg::*;

  blk_t t;
  blk_t k;
  blk_t m;
  byte_t a0, a1, a2, a3;
  byte_t b [4];
  byte_t c2, c4, c8;

  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        t[c*4+j] = INV_SBOX[in_blk[((c - j + 4) % 4) * 4 + j]];
    k = t ^ RKEYS[ROUND];
    m = k;
    if (ROUND > 0) begin
      for (int c = 0; c < 4; c++) begin
        a0 = k[c*4]; a1 = k[c*4+1]; a2 = k[c*4+2]; a3 = k[c*4+3];
        b[0] = a0; b[1] = a1; b[2] = a2; b[3] = a3;
        for (int r = 0; r < 4; r++) begin
          // row r: 14,11,13,9 rotated
          m[c*4+r] = 8'h00;
          for (int q = 0; q < 4; q++) begin
            c2 = xt(b[(r + q) % 4]);
            c4 = xt(c2);
            c8 = xt(c4);
            case (q)
              0:       m[c*4+r] = m[c*4+r] ^ c8 ^ c4 ^ c2;
              1:       m[c*4+r] = m[c*4+r] ^ c8 ^ c2 ^ b[(r + q) % 4];
              2:       m[c*4+r] = m[c*4+r] ^ c8 ^ c4 ^ b[(r + q) % 4];
              default: m[c*4+r] = m[c*4+r] ^ c8 ^ b[(r + q) % 4];
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_blk <= m;
    end
  end

endmodule
`default_nettype wire

>>> design/rtkd_mix_stage.sv
// rtkd_mix_stage: one registered round of mask xor, chained xor and borrow subtract
// depends on rtkd_pkg
`default_nettype none
module rtkd_mix_stage (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_vld,
  input  wire rtkd_pkg::blk_t in_blk,
  output logic              out_vld,
  output rtkd_pkg::blk_t    out_blk
);
  import rtkd_pkg::*;

  blk_t         x;
  blk_t         y;
  blk_t         z;
  logic [127:0] n;
  logic [127:0] d;

  always_comb begin
    x = in_blk ^ MASK_TAB;
    y = x;
    for (int i = 1; i < NBYTES; i++) y[PERM[i]] = x[PERM[i]] ^ x[PERM[i-1]];
    // borrow chain along the permutation is a plain wide subtract
    for (int i = 0; i < NBYTES; i++) n[8*i +: 8] = y[PERM[i]];
    d = n - SUB_WORD;
    z = y;
    for (int i = 0; i < NBYTES; i++) z[PERM[i]] = d[8*i +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_blk <= z;
    end
  end

endmodule
`default_nettype wire

>>> design/rap_to_license_key_derivation_core.sv
// rap_to_license_key_derivation_core: pipelined aes-128 decrypt plus five mix rounds
// depends on rtkd_pkg, rtkd_aes_stage, rtkd_mix_stage
`default_nettype none
// channel  | direction | word
// ---------+-----------+-----------------------------------------
// in       | input     | key_in_t: key_in_high, key_in_low
// out      | output    | derived_t: derived_high, derived_low
//
// one word per cycle sustained while out is not stalled
// stage 0 adds the last round key, stages 1-10 are the inverse aes rounds,
// stages 11-15 are the five mix rounds; the last stage is the output register
// a stall on out freezes the whole pipe; in_ready drops only while out is
// stalled with a word waiting
// synchronous reset clears all valid bits; data registers are not reset
module rap_to_license_key_derivation_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire rtkd_pkg::key_in_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output rtkd_pkg::derived_t  out_data
);
  import rtkd_pkg::*;

  localparam int NSTG = AES_NR + NROUNDS + 1;

  // pipe advance: everything shifts unless the output word is held
  logic adv;
  logic [NSTG-1:0] vld;
  blk_t            blk [NSTG];
  logic            vld_s0;
  blk_t            blk_s0;

  assign adv      = !vld[NSTG-1] || out_ready;
  assign in_ready = adv;

  // stage 0: initial add of the last round key
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s0 <= 1'b0;
    end else if (adv) begin
      vld_s0 <= in_valid;
    end
    if (adv) begin
      blk_s0 <= blk_t'({in_data.key_in_high, in_data.key_in_low}) ^ RKEYS[AES_NR];
    end
  end

  assign vld[0] = vld_s0;
  assign blk[0] = blk_s0;

  // inverse aes rounds 9 down to 0
  for (genvar g = 0; g < AES_NR; g++) begin : g_aes
    rtkd_aes_stage #(.ROUND(AES_NR - 1 - g)) u_aes (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (vld[g]),
      .in_blk  (blk[g]),
      .out_vld (vld[g+1]),
      .out_blk (blk[g+1])
    );
  end

  // mix rounds
  for (genvar g = 0; g < NROUNDS; g++) begin : g_mix
    rtkd_mix_stage u_mix (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (vld[AES_NR + g]),
      .in_blk  (blk[AES_NR + g]),
      .out_vld (vld[AES_NR + g + 1]),
      .out_blk (blk[AES_NR + g + 1])
    );
  end

  assign out_valid             = vld[NSTG-1];
  assign out_data.derived_high = blk[NSTG-1][0:7];
  assign out_data.derived_low  = blk[NSTG-1][8:15];

`ifndef SYNTHESIS
  // reset empties the whole pipe
  a_reset_clears: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipe not empty after reset");
  // a frozen pipe keeps every valid bit
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("valid bits moved during stall");
  // a word entering reaches stage 0 on the next edge
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word lost at entry");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking bench for rap_to_license_key_derivation_core
// depends on rtkd_pkg (word types) and the core; computes expected derived keys itself
`default_nettype none
module tb;
  import rtkd_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int LATENCY     = 16;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  key_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  derived_t out_data;

  // expected derived keys, oldest first
  derived_t derived_q[$];
  int       err_count = 0;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;   // receiver forced to stall for a long stretch
  bit       bursty = 1'b1;     // sender gaps enabled
  bit       rx_random = 1'b1;  // receiver stall pattern enabled

  // own tables for the predictor
  logic [7:0] sb [256];
  logic [7:0] isb [256];
  logic [7:0] rkey [176];
  logic [7:0] perm_t [16];
  logic [7:0] mask_t [16];
  logic [7:0] sub_t [16];

  always #10 clk = ~clk;

  rap_to_license_key_derivation_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    while (b != 0) begin
      if (b[0]) r ^= a;
      a = dbl(a);
      b = b >> 1;
    end
    return r;
  endfunction

  // sbox via gf inverse and affine map, key schedule from the fixed key
  task automatic build_tables();
    logic [7:0] inv, x, rc;
    logic [7:0] tmp [4];
    logic [7:0] fixed_key [16] = '{8'h86,8'h9F,8'h77,8'h45,8'hC1,8'h3F,8'hD8,8'h90,
                                   8'hCC,8'hF2,8'h91,8'h88,8'hE3,8'hCC,8'h3E,8'hDF};
    perm_t = '{8'h0C,8'h03,8'h06,8'h04,8'h01,8'h0B,8'h0F,8'h08,
               8'h02,8'h07,8'h00,8'h05,8'h0A,8'h0E,8'h0D,8'h09};
    mask_t = '{8'hA9,8'h3E,8'h1F,8'hD6,8'h7C,8'h55,8'hA3,8'h29,
               8'hB7,8'h5F,8'hDD,8'hA6,8'h2A,8'h95,8'hC7,8'hA5};
    sub_t  = '{8'h67,8'hD4,8'h5D,8'hA3,8'h29,8'h6D,8'h00,8'h6A,
               8'h4E,8'h7C,8'h53,8'h7B,8'hF5,8'h53,8'h8C,8'h74};
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (a != 0 && gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[a] = x;
      isb[x] = a[7:0];
    end
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rkey[i] = fixed_key[i];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tmp[j] = rkey[i-4+j];
      if (i % 16 == 0) begin
        x = tmp[0];
        tmp[0] = sb[tmp[1]] ^ rc;
        tmp[1] = sb[tmp[2]];
        tmp[2] = sb[tmp[3]];
        tmp[3] = sb[x];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rkey[i+j] = rkey[i-16+j] ^ tmp[j];
    end
  endtask

  // aes-128 block decrypt then five mask / chain / borrow-subtract rounds
  function automatic derived_t derive_key(input key_in_t w);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, kc;
    logic [127:0] flat;
    int p, q;
    bit borrow;
    flat = w;
    for (int i = 0; i < 16; i++) s[i] = flat[127-8*i -: 8] ^ rkey[160+i];
    for (int r = 9; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[c*4+j] = isb[s[((c-j+4)%4)*4+j]];
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkey[r*16+i];
      if (r > 0)
        for (int c = 0; c < 4; c++) begin
          a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
          s[c*4]   = gf_mul(a0,8'd14) ^ gf_mul(a1,8'd11) ^ gf_mul(a2,8'd13) ^ gf_mul(a3,8'd9);
          s[c*4+1] = gf_mul(a0,8'd9)  ^ gf_mul(a1,8'd14) ^ gf_mul(a2,8'd11) ^ gf_mul(a3,8'd13);
          s[c*4+2] = gf_mul(a0,8'd13) ^ gf_mul(a1,8'd9)  ^ gf_mul(a2,8'd14) ^ gf_mul(a3,8'd11);
          s[c*4+3] = gf_mul(a0,8'd11) ^ gf_mul(a1,8'd13) ^ gf_mul(a2,8'd9)  ^ gf_mul(a3,8'd14);
        end
    end
    for (int rnd = 0; rnd < 5; rnd++) begin
      borrow = 1'b0;
      for (int i = 0; i < 16; i++) s[perm_t[i]] ^= mask_t[perm_t[i]];
      for (int i = 15; i >= 1; i--) begin
        p = perm_t[i];
        q = perm_t[i-1];
        s[p] ^= s[q];
      end
      for (int i = 0; i < 16; i++) begin
        p = perm_t[i];
        kc = s[p] - borrow;
        // borrow through a zero byte keeps the borrow set
        if (!(borrow && kc == 8'hFF)) borrow = (kc < sub_t[p]);
        s[p] = kc - sub_t[p];
      end
    end
    for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = s[i];
    return flat;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    err_count++;
  endtask

  // send one word; valid stays high across back-to-back words
  task automatic send_word(input key_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    derived_q.push_back(derive_key(w));
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic key_in_t rand_word();
    key_in_t w;
    w = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 7))
      0: w.key_in_high = '0;
      1: w.key_in_low  = '1;
      2: w = w & {4{32'h0101_0101}};
      default: ;
    endcase
    return w;
  endfunction

  // extremes, walking ones and byte patterns
  task automatic test_directed();
    send_word('0);
    send_word('1);
    send_word({64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
    send_word({64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
    send_word({64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F});
    send_word({64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001});
    send_word({64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
    for (int i = 0; i < 16; i++) send_word(128'h1 << (i * 8 + i % 8));
    idle_sender();
  endtask

  // random words with bursty sender and random receiver
  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_word(rand_word());
    idle_sender();
  endtask

  // back-to-back words with no gaps in either direction
  task automatic test_streaming(input int n);
    bursty = 1'b0;
    rx_random = 1'b0;
    for (int i = 0; i < n; i++) send_word(rand_word());
    idle_sender();
    bursty = 1'b1;
    rx_random = 1'b1;
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure(input int n);
    bursty = 1'b0;
    hold_off = 1'b1;
    for (int i = 0; i < n; i++) send_word(rand_word());
    idle_sender();
    wait (!hold_off);
    bursty = 1'b1;
  endtask

  // long stall counted in its own process
  initial begin
    wait (hold_off);
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // receiver ready pattern
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (!rx_random) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 15) < 11);
  end

  // compare each accepted word against the oldest expected derived key
  always @(posedge clk) begin
    derived_t want;
    if (!rst && out_valid && out_ready) begin
      if (derived_q.size() == 0) begin
        report_mismatch("unexpected word", out_data.derived_high, 64'h0);
      end else begin
        want = derived_q.pop_front();
        if (out_data.derived_high !== want.derived_high)
          report_mismatch("derived_high", out_data.derived_high, want.derived_high);
        if (out_data.derived_low !== want.derived_low)
          report_mismatch("derived_low", out_data.derived_low, want.derived_low);
      end
    end
  end

  // watchdog on cycles with no word moving in either direction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int waited;
    build_tables();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure(60);
    test_streaming(150);
    test_random(620);
    // drain the pipe
    waited = 0;
    while (derived_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (err_count == 0 && derived_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (derived_q.size() != 0) $display("%0d expected words never arrived", derived_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
